[rtl/core/cma_pkg.sv]
// Shared constants and types for the confusion matrix accumulator.
package cma_pkg;

  localparam int NUM_CLASSES = 8;
  localparam int COUNT_BITS  = 32;
  localparam int OUT_BITS    = 32;
  localparam int LABEL_W     = $clog2(NUM_CLASSES);
  localparam int CELLS       = NUM_CLASSES * NUM_CLASSES;
  localparam int CELL_AW     = $clog2(CELLS);
  localparam int ACTIVE_W    = 4;
  localparam int PADDR_W     = 2;
  localparam int PDATA_W     = 32;

  // byte address of the active_classes register
  localparam logic [PADDR_W-1:0] ADDR_ACTIVE = '0;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);
  localparam logic [ACTIVE_W-1:0] CLASS_LIMIT  = ACTIVE_W'(NUM_CLASSES);

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

[rtl/core/cma_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module cma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/confusion_matrix_accumulator_top.sv]
// Confusion matrix accumulator: cell counts in RAM, class totals and globals in flops.
//
//   channel   signals                                   direction  handshake
//   request   start, busy, in_operation, in_*_label     in         start & !busy
//   result    out_valid, out_status, out_*_total/count  out        one-cycle strobe
//   config    psel, penable, pwrite, paddr, pwdata      in         APB write, pready=1
//
// On a request, the accept edge issues the cell RAM read and the
// next edge (busy high) does the read-modify-write and registers the result.
// out_valid is high in the cycle after that edge; a new request can be taken
// at the edge that ends it. The registered RAM read sets the spacing.
// Synchronous active-low reset clears all counts; per-cell valid bits mask stale
// RAM entries, so neither reset nor a clear request needs a pass. No stalls.
module confusion_matrix_accumulator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_operation,
  input  logic [cma_pkg::LABEL_W-1:0]  in_true_label,
  input  logic [cma_pkg::LABEL_W-1:0]  in_predicted_label,
  // result channel
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [cma_pkg::OUT_BITS-1:0] out_cell_count,
  output logic [cma_pkg::OUT_BITS-1:0] out_row_total,
  output logic [cma_pkg::OUT_BITS-1:0] out_column_total,
  output logic [cma_pkg::OUT_BITS-1:0] out_sample_total,
  output logic [cma_pkg::OUT_BITS-1:0] out_correct_total,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cma_pkg::PADDR_W-1:0]  paddr,
  input  logic [cma_pkg::PDATA_W-1:0]  pwdata,
  output logic [cma_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  // ---------------------------------------------------------------------------
  // Control and captured request
  // ---------------------------------------------------------------------------
  cma_pkg::state_t state_r, state_nxt;
  logic                        accept;
  logic                        exec_en;

  logic [1:0]                  op_r;
  logic [cma_pkg::LABEL_W-1:0] row_r;
  logic [cma_pkg::LABEL_W-1:0] col_r;

  logic [cma_pkg::ACTIVE_W-1:0] active_r, active_nxt;
  logic                         cfg_wr;

  // Count state
  logic [cma_pkg::CELLS-1:0] valid_r, valid_nxt;
  cma_pkg::count_t row_tot_r [cma_pkg::NUM_CLASSES];
  cma_pkg::count_t row_tot_nxt [cma_pkg::NUM_CLASSES];
  cma_pkg::count_t col_tot_r [cma_pkg::NUM_CLASSES];
  cma_pkg::count_t col_tot_nxt [cma_pkg::NUM_CLASSES];
  cma_pkg::count_t seen_r, seen_nxt;
  cma_pkg::count_t correct_r, correct_nxt;

  // Cell RAM
  logic                        ram_we;
  logic [cma_pkg::CELL_AW-1:0] ram_raddr;
  logic [cma_pkg::CELL_AW-1:0] cell_idx;
  cma_pkg::count_t             ram_rdata;
  cma_pkg::count_t             ram_wdata;

  // Datapath
  logic [cma_pkg::ACTIVE_W-1:0] limit;
  logic            in_range;
  logic            do_record;
  logic            do_lookup;
  logic            do_clear;
  logic            diag;
  cma_pkg::count_t cell_cur, row_cur, col_cur;
  cma_pkg::count_t cell_inc, row_inc, col_inc, seen_inc, correct_inc;
  logic            any_sat;

  // Result registers
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic [cma_pkg::OUT_BITS-1:0] cell_out_r, cell_out_nxt;
  logic [cma_pkg::OUT_BITS-1:0] row_out_r, row_out_nxt;
  logic [cma_pkg::OUT_BITS-1:0] col_out_r, col_out_nxt;
  logic [cma_pkg::OUT_BITS-1:0] seen_out_r, seen_out_nxt;
  logic [cma_pkg::OUT_BITS-1:0] correct_out_r, correct_out_nxt;

  // Saturating increment: stays at all-ones
  function automatic cma_pkg::count_t bump(input cma_pkg::count_t cnt);
    bump = (&cnt) ? cnt : cnt + cma_pkg::COUNT_BITS'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // FSM
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cma_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = cma_pkg::ST_EXEC;
        end
      end
      cma_pkg::ST_EXEC: begin
        state_nxt = cma_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    exec_en = 1'b0;
    case (state_r)
      cma_pkg::ST_IDLE: begin
        busy    = 1'b0;
        exec_en = 1'b0;
      end
      cma_pkg::ST_EXEC: begin
        busy    = 1'b1;
        exec_en = 1'b1;
      end
      default: begin
        busy    = 1'b0;
        exec_en = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Configuration: single register at byte address 0
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {{(cma_pkg::PDATA_W - cma_pkg::ACTIVE_W){1'b0}}, active_r};

  always_comb begin
    active_nxt = active_r;
    if (cfg_wr && (paddr == cma_pkg::ADDR_ACTIVE)) begin
      active_nxt = pwdata[cma_pkg::ACTIVE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Cell RAM: read issued at accept, written back in EXEC
  // ---------------------------------------------------------------------------
  assign ram_raddr = {in_true_label, in_predicted_label};
  assign cell_idx  = {row_r, col_r};

  cma_ram #(
    .WIDTH (cma_pkg::COUNT_BITS),
    .DEPTH (cma_pkg::CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cell_idx),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Read-modify-write datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    limit = (active_r > cma_pkg::CLASS_LIMIT) ? cma_pkg::CLASS_LIMIT : active_r;
    in_range = ({1'b0, row_r} < limit) && ({1'b0, col_r} < limit);
    do_clear  = exec_en && (op_r == cma_pkg::OP_CLEAR);
    do_lookup = exec_en && (op_r != cma_pkg::OP_CLEAR) && in_range;
    do_record = do_lookup && (op_r == cma_pkg::OP_RECORD);
    diag      = (row_r == col_r);

    // never-written cells read as zero
    cell_cur = valid_r[cell_idx] ? ram_rdata : '0;
    row_cur  = row_tot_r[row_r];
    col_cur  = col_tot_r[col_r];

    cell_inc    = bump(cell_cur);
    row_inc     = bump(row_cur);
    col_inc     = bump(col_cur);
    seen_inc    = bump(seen_r);
    correct_inc = diag ? bump(correct_r) : correct_r;

    any_sat = (&cell_cur) || (&row_cur) || (&col_cur) || (&seen_r) ||
              (diag && (&correct_r));

    ram_we    = do_record;
    ram_wdata = cell_inc;
  end

  always_comb begin
    valid_nxt   = valid_r;
    row_tot_nxt = row_tot_r;
    col_tot_nxt = col_tot_r;
    seen_nxt    = seen_r;
    correct_nxt = correct_r;
    if (do_clear) begin
      valid_nxt   = '0;
      seen_nxt    = '0;
      correct_nxt = '0;
      for (int i = 0; i < cma_pkg::NUM_CLASSES; i++) begin
        row_tot_nxt[i] = '0;
        col_tot_nxt[i] = '0;
      end
    end else if (do_record) begin
      valid_nxt[cell_idx] = 1'b1;
      row_tot_nxt[row_r]  = row_inc;
      col_tot_nxt[col_r]  = col_inc;
      seen_nxt            = seen_inc;
      correct_nxt         = correct_inc;
    end
  end

  // Result formation
  always_comb begin
    out_valid_nxt   = exec_en;
    status_nxt      = status_r;
    cell_out_nxt    = cell_out_r;
    row_out_nxt     = row_out_r;
    col_out_nxt     = col_out_r;
    seen_out_nxt    = seen_out_r;
    correct_out_nxt = correct_out_r;
    if (exec_en) begin
      if (do_clear) begin
        status_nxt      = cma_pkg::STAT_OK;
        cell_out_nxt    = '0;
        row_out_nxt     = '0;
        col_out_nxt     = '0;
        seen_out_nxt    = '0;
        correct_out_nxt = '0;
      end else if (!in_range) begin
        status_nxt      = cma_pkg::STAT_RANGE;
        cell_out_nxt    = '0;
        row_out_nxt     = '0;
        col_out_nxt     = '0;
        seen_out_nxt    = cma_pkg::OUT_BITS'(seen_r);
        correct_out_nxt = cma_pkg::OUT_BITS'(correct_r);
      end else if (do_record) begin
        status_nxt      = any_sat ? cma_pkg::STAT_SAT : cma_pkg::STAT_OK;
        cell_out_nxt    = cma_pkg::OUT_BITS'(cell_inc);
        row_out_nxt     = cma_pkg::OUT_BITS'(row_inc);
        col_out_nxt     = cma_pkg::OUT_BITS'(col_inc);
        seen_out_nxt    = cma_pkg::OUT_BITS'(seen_inc);
        correct_out_nxt = cma_pkg::OUT_BITS'(correct_inc);
      end else begin
        // read, and the spare code which behaves as a read
        status_nxt      = cma_pkg::STAT_OK;
        cell_out_nxt    = cma_pkg::OUT_BITS'(cell_cur);
        row_out_nxt     = cma_pkg::OUT_BITS'(row_cur);
        col_out_nxt     = cma_pkg::OUT_BITS'(col_cur);
        seen_out_nxt    = cma_pkg::OUT_BITS'(seen_r);
        correct_out_nxt = cma_pkg::OUT_BITS'(correct_r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cma_pkg::ST_IDLE;
      active_r    <= cma_pkg::ACTIVE_RESET;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      seen_r      <= '0;
      correct_r   <= '0;
      for (int i = 0; i < cma_pkg::NUM_CLASSES; i++) begin
        row_tot_r[i] <= '0;
        col_tot_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      seen_r      <= seen_nxt;
      correct_r   <= correct_nxt;
      row_tot_r   <= row_tot_nxt;
      col_tot_r   <= col_tot_nxt;
    end
  end

  // captured request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      row_r <= in_true_label;
      col_r <= in_predicted_label;
    end
    status_r      <= status_nxt;
    cell_out_r    <= cell_out_nxt;
    row_out_r     <= row_out_nxt;
    col_out_r     <= col_out_nxt;
    seen_out_r    <= seen_out_nxt;
    correct_out_r <= correct_out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_cell_count    = cell_out_r;
  assign out_row_total     = row_out_r;
  assign out_column_total  = col_out_r;
  assign out_sample_total  = seen_out_r;
  assign out_correct_total = correct_out_r;

endmodule

[sim/confusion_matrix_accumulator_checker.sv]
// Checker: predicts each confusion matrix result and compares it with what the block returns.
module confusion_matrix_accumulator_checker #(
  parameter logic [cma_pkg::PADDR_W-1:0] ACTIVE_ADDR = '0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   in_operation,
  input  logic [cma_pkg::LABEL_W-1:0]  in_true_label,
  input  logic [cma_pkg::LABEL_W-1:0]  in_predicted_label,
  input  logic                         out_valid,
  input  logic [1:0]                   out_status,
  input  logic [cma_pkg::OUT_BITS-1:0] out_cell_count,
  input  logic [cma_pkg::OUT_BITS-1:0] out_row_total,
  input  logic [cma_pkg::OUT_BITS-1:0] out_column_total,
  input  logic [cma_pkg::OUT_BITS-1:0] out_sample_total,
  input  logic [cma_pkg::OUT_BITS-1:0] out_correct_total,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [cma_pkg::PADDR_W-1:0]  paddr,
  input  logic [cma_pkg::PDATA_W-1:0]  pwdata,
  output int                           mismatch_count,
  output int                           pending
);
  import cma_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]          status;
    logic [OUT_BITS-1:0] pair;
    logic [OUT_BITS-1:0] row;
    logic [OUT_BITS-1:0] column;
    logic [OUT_BITS-1:0] samples;
    logic [OUT_BITS-1:0] correct;
  } matrix_report_t;

  matrix_report_t report_q[$];

  count_t              pair_cnt [CELLS];
  count_t              true_tot [NUM_CLASSES];
  count_t              pred_tot [NUM_CLASSES];
  count_t              seen_cnt;
  count_t              correct_cnt;
  logic [ACTIVE_W-1:0] class_reg;

  function automatic void clear_matrix();
    for (int i = 0; i < CELLS; i++) pair_cnt[i] = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      true_tot[i] = '0;
      pred_tot[i] = '0;
    end
    seen_cnt    = '0;
    correct_cnt = '0;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Applies one request to the shadow matrix and returns the result it produces.
  function automatic matrix_report_t tally_request(input op_t op,
                                                   input logic [LABEL_W-1:0] t,
                                                   input logic [LABEL_W-1:0] p);
    matrix_report_t rep;
    int             span;
    int             idx;
    logic           sat;
    rep  = '0;
    span = (class_reg > CLASS_LIMIT) ? NUM_CLASSES : int'(class_reg);
    idx  = int'(t) * NUM_CLASSES + int'(p);
    if (op == OP_CLEAR) begin
      clear_matrix();
    end else if (int'(t) >= span || int'(p) >= span) begin
      rep.status = STAT_RANGE;
    end else begin
      if (op == OP_RECORD) begin
        sat = (pair_cnt[idx] == '1) | (true_tot[t] == '1) | (pred_tot[p] == '1) |
              (seen_cnt == '1) | ((t == p) && (correct_cnt == '1));
        pair_cnt[idx] = sat_inc(pair_cnt[idx]);
        true_tot[t]   = sat_inc(true_tot[t]);
        pred_tot[p]   = sat_inc(pred_tot[p]);
        seen_cnt      = sat_inc(seen_cnt);
        if (t == p) correct_cnt = sat_inc(correct_cnt);
        if (sat) rep.status = STAT_SAT;
      end
      rep.pair   = OUT_BITS'(pair_cnt[idx]);
      rep.row    = OUT_BITS'(true_tot[t]);
      rep.column = OUT_BITS'(pred_tot[p]);
    end
    rep.samples = OUT_BITS'(seen_cnt);
    rep.correct = OUT_BITS'(correct_cnt);
    return rep;
  endfunction

  task automatic report_mismatch(input string why, input matrix_report_t want,
                                 input matrix_report_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, why);
      $display("  expected status=%0d cell=%0d row=%0d col=%0d samples=%0d correct=%0d",
               want.status, want.pair, want.row, want.column, want.samples,
               want.correct);
      $display("  actual   status=%0d cell=%0d row=%0d col=%0d samples=%0d correct=%0d",
               got.status, got.pair, got.row, got.column, got.samples, got.correct);
    end
  endtask

  always @(posedge clk) begin : watch
    matrix_report_t got;
    matrix_report_t want;
    matrix_report_t fresh;
    if (!rst_n) begin
      clear_matrix();
      class_reg = ACTIVE_RESET;
      report_q.delete();
      mismatch_count = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        got = {out_status, out_cell_count, out_row_total, out_column_total,
               out_sample_total, out_correct_total};
        if (report_q.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = report_q.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
      if (psel && penable && pwrite && pready && paddr == ACTIVE_ADDR)
        class_reg = pwdata[ACTIVE_W-1:0];
      if (start && !busy) begin
        fresh = tally_request(op_t'(in_operation), in_true_label, in_predicted_label);
        report_q.insert(report_q.size(), fresh);
      end
      pending <= report_q.size();
    end
  end

endmodule

[sim/confusion_matrix_accumulator_top_tb.sv]
// Testbench top: drives label requests and class-count writes, then reports the verdict.
module confusion_matrix_accumulator_top_tb;
  import cma_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASES         = 10;
  localparam int TAIL_CYCLES    = 8;
  // active_classes is the only register, at byte address 0
  localparam logic [PADDR_W-1:0] ACTIVE_ADDR = '0;

  // every input starts at a known value
  logic                 clk                = 1'b0;
  logic                 rst_n              = 1'b0;
  logic                 start              = 1'b0;
  logic [1:0]           in_operation       = '0;
  logic [LABEL_W-1:0]   in_true_label      = '0;
  logic [LABEL_W-1:0]   in_predicted_label = '0;
  logic                 psel               = 1'b0;
  logic                 penable            = 1'b0;
  logic                 pwrite             = 1'b0;
  logic [PADDR_W-1:0]   paddr              = '0;
  logic [PDATA_W-1:0]   pwdata             = '0;

  logic                 busy;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [OUT_BITS-1:0]  out_cell_count;
  logic [OUT_BITS-1:0]  out_row_total;
  logic [OUT_BITS-1:0]  out_column_total;
  logic [OUT_BITS-1:0]  out_sample_total;
  logic [OUT_BITS-1:0]  out_correct_total;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int mismatch_count;
  int pending;

  // labels below class_span are accepted by the block under the current setting
  int class_span = NUM_CLASSES;
  int n_record   = 0;
  int n_read     = 0;
  int n_clear    = 0;
  int n_spare    = 0;
  int n_writes   = 0;

  always #CLK_HALF clk = ~clk;

  confusion_matrix_accumulator_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_true_label      (in_true_label),
    .in_predicted_label (in_predicted_label),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_cell_count     (out_cell_count),
    .out_row_total      (out_row_total),
    .out_column_total   (out_column_total),
    .out_sample_total   (out_sample_total),
    .out_correct_total  (out_correct_total),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // The checker watches both channels and the config port on its own;
  // this module only makes stimulus.
  confusion_matrix_accumulator_checker #(
    .ACTIVE_ADDR (ACTIVE_ADDR)
  ) u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_true_label      (in_true_label),
    .in_predicted_label (in_predicted_label),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_cell_count     (out_cell_count),
    .out_row_total      (out_row_total),
    .out_column_total   (out_column_total),
    .out_sample_total   (out_sample_total),
    .out_correct_total  (out_correct_total),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .mismatch_count     (mismatch_count),
    .pending            (pending)
  );

  // Raise start with the request fields and hold them until the accept edge
  // (start high, busy low). Returns in the time step of that edge, so the
  // caller may drive the next request right away without dropping start.
  task automatic send_label_request(input op_t op, input logic [LABEL_W-1:0] t,
                                    input logic [LABEL_W-1:0] p);
    start              <= 1'b1;
    in_operation       <= op;
    in_true_label      <= t;
    in_predicted_label <= p;
    case (op)
      OP_RECORD: n_record++;
      OP_READ:   n_read++;
      OP_CLEAR:  n_clear++;
      default:   n_spare++;
    endcase
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender gap; the fields carry junk while start is low.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      start              <= 1'b0;
      in_operation       <= 2'($urandom());
      in_true_label      <= LABEL_W'($urandom());
      in_predicted_label <= LABEL_W'($urandom());
      @(posedge clk);
    end
  endtask

  // Hold off new requests until every outstanding result has come back.
  // The checker's pending count is a registered copy, so the first edge after the
  // last accept already shows that request.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // APB write of active_classes, only with the block idle. Upper data bits
  // carry junk that the register must drop.
  task automatic write_class_count(input logic [ACTIVE_W-1:0] v);
    logic [PDATA_W-1:0] junk;
    junk = $urandom();
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_ADDR;
    pwdata  <= {junk[PDATA_W-1:ACTIVE_W], v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    class_span = (v > CLASS_LIMIT) ? NUM_CLASSES : int'(v);
    n_writes++;
  endtask

  // Mostly in-range labels so the counts build up; the rest anywhere in 0..7.
  function automatic logic [LABEL_W-1:0] pick_label();
    if (class_span > 0 && $urandom_range(0, 99) < 85)
      return LABEL_W'($urandom_range(0, class_span - 1));
    return LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
  endfunction

  initial begin : stimulus
    op_t                op;
    int                 r;
    int                 burst;
    int                 sent;
    int                 quota;
    logic [ACTIVE_W-1:0] setting;
    logic [LABEL_W-1:0] t;
    logic [LABEL_W-1:0] p;
    logic [LABEL_W-1:0] last_t;
    logic [LABEL_W-1:0] last_p;
    last_t = '0;
    last_p = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: reset value of 8 classes ---
    send_label_request(OP_READ,   3'd0, 3'd0);   // empty matrix
    send_label_request(OP_RECORD, 3'd0, 3'd0);   // correct sample, lowest labels
    send_label_request(OP_RECORD, 3'd7, 3'd7);   // correct sample, highest labels
    send_label_request(OP_RECORD, 3'd7, 3'd0);
    send_label_request(OP_RECORD, 3'd0, 3'd7);
    send_label_request(OP_RECORD, 3'd0, 3'd7);   // back-to-back hit on one cell
    idle_cycles(1);
    send_label_request(OP_READ,   3'd0, 3'd7);
    send_label_request(OP_SPARE,  3'd7, 3'd0);   // spare code reads, changes nothing
    send_label_request(OP_READ,   3'd7, 3'd7);
    send_label_request(OP_CLEAR,  3'd5, 3'd3);   // clear ignores the labels
    send_label_request(OP_READ,   3'd0, 3'd7);

    // two classes: labels 2 and up are out of range
    write_class_count(4'd2);
    send_label_request(OP_RECORD, 3'd2, 3'd0);
    send_label_request(OP_RECORD, 3'd1, 3'd1);
    send_label_request(OP_RECORD, 3'd0, 3'd2);
    send_label_request(OP_READ,   3'd1, 3'd1);
    send_label_request(OP_READ,   3'd7, 3'd7);

    // zero classes rejects every label pair (a clear still runs), one class takes only label 0
    write_class_count(4'd0);
    send_label_request(OP_RECORD, 3'd0, 3'd0);
    send_label_request(OP_CLEAR,  3'd7, 3'd7);
    write_class_count(4'd1);
    send_label_request(OP_RECORD, 3'd0, 3'd0);
    send_label_request(OP_RECORD, 3'd0, 3'd1);

    // above the built-in class count: clamped to eight
    write_class_count(4'd15);
    send_label_request(OP_RECORD, 3'd7, 3'd7);
    send_label_request(OP_READ,   3'd7, 3'd7);

    // --- random phases, one class-count setting each ---
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       setting = 4'd8;
        1:       setting = 4'd2;
        2:       setting = 4'd15;
        3:       setting = 4'd1;
        4:       setting = 4'd5;
        5:       setting = 4'd0;
        6:       setting = 4'd3;
        7:       setting = 4'd7;
        8:       setting = 4'd8;
        default: setting = 4'd4;
      endcase
      write_class_count(setting);
      // settings that reject nearly everything get a short phase
      quota = (class_span < 2) ? 40 : 210;
      sent  = 0;
      while (sent < quota) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          r = $urandom_range(0, 99);
          if (r < 60)      op = OP_RECORD;
          else if (r < 84) op = OP_READ;
          else if (r < 88) op = OP_CLEAR;
          else             op = OP_SPARE;
          // some repeats of the last pair to stress back-to-back updates of one cell
          if ($urandom_range(0, 4) == 0) begin
            t = last_t;
            p = last_p;
          end else begin
            t = pick_label();
            p = pick_label();
          end
          last_t = t;
          last_p = p;
          send_label_request(op, t, p);
          sent++;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
          wait_for_results();            // full drain mid-phase
        else if (r >= 30)
          idle_cycles($urandom_range(1, 8));
        // else: next burst follows with start held high
      end
    end

    // let everything come back, then a few cycles for any stray result
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d record, %0d read, %0d clear, %0d spare code",
             n_record + n_read + n_clear + n_spare, n_record, n_read, n_clear, n_spare);
    $display("over %0d class-count writes; %0d bad results, %0d still outstanding",
             n_writes, mismatch_count, pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Mismatches found");
    $finish;
  end

endmodule

[confusion_matrix_accumulator_top.f]
rtl/core/cma_pkg.sv
rtl/core/cma_ram.sv
rtl/core/confusion_matrix_accumulator_top.sv
sim/confusion_matrix_accumulator_checker.sv
sim/confusion_matrix_accumulator_top_tb.sv
